@@ hw/rtl/sba_pkg.sv @@
// Package: shared widths, codes, payload structs and controller/datapath interface types.
`timescale 1ns / 1ps

package sba_pkg;

    // Slab geometry
    localparam int MAX_OBJECTS = 128;
    localparam int IDX_W       = $clog2(MAX_OBJECTS);
    localparam int ADDR_W      = 48;
    localparam int STRIDE_W    = 21;
    localparam int COUNT_W     = 8;
    localparam int CFG_IDX_W   = 2;

    // Free-slot scan: SCAN_W map bits examined per cycle
    localparam int SCAN_W      = 8;
    localparam int SCAN_SEL_W  = $clog2(SCAN_W);
    localparam int CHUNKS      = MAX_OBJECTS / SCAN_W;
    localparam int CHUNK_W     = $clog2(CHUNKS);

    // Divider remainder width: offset inside the slab is below MAX_OBJECTS * stride
    localparam int REM_W       = STRIDE_W + IDX_W;
    localparam int SPAN_W      = STRIDE_W + COUNT_W;
    localparam int PROD_W      = STRIDE_W + IDX_W;
    localparam int STEP_W      = $clog2(IDX_W);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd2;

    // Request actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_OUTSIDE = 2'd2,
        ST_DOUBLE  = 2'd3
    } status_t;

    // Input item
    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] address;
    } req_t;

    // Result item
    typedef struct packed {
        status_t            status;
        logic [ADDR_W-1:0]  object_address;
        logic [IDX_W-1:0]   object_index;
        logic [COUNT_W-1:0] free_objects;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    capture;
        logic    scan;
        logic    range_calc;
        logic    div_step;
        logic    commit;
        logic    mul;
        logic    add;
        logic    set_status;
        status_t status_code;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_found;
        logic scan_last;
        logic outside;
        logic div_last;
        logic is_used;
    } sts_t;

endpackage

@@ hw/rtl/slab_bitmap_object_allocator_core.sv @@
// Top level: slab bitmap object allocator, controller plus datapath.
`timescale 1ns / 1ps

// Usage:
// A request (allocate, or free an address) is accepted at a rising edge with
// start high and busy low. busy stays high until the result has been shown.
// The result is valid on 'result' while 'done' is high for a single cycle; the
// receiver takes it in that cycle and cannot stall it.
// An allocate scans the used map, one 8-object chunk after another (at most
// 16 chunks), for the lowest free object and then forms its address; a full
// slab ends the request once the last chunk inside the slab is scanned. A free
// checks that the address lies inside the slab and if not ends there, finds
// the object index with the one-bit-per-cycle restoring divider (7 steps),
// reads one map word, and on a double free ends there; else it clears the bit
// and forms the address. One request is in flight at a time and the next may
// be accepted the cycle after done.
// Configuration: cfg_valid/cfg_ready transfer (always ready) with register
// index 0 region_base, 1 object_stride, 2 object_count; writing object_count
// frees every object at once through per-word flags. Write only while idle.
// Reset: all objects free, base 0, stride 32, count 128; no clearing pass.
module slab_bitmap_object_allocator_core
    import sba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  req_t                 request,
    output logic                 done,
    output rsp_t                 result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    sba_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (request.action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    sba_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

@@ hw/rtl/sba_ctrl.sv @@
// Controller: sequences allocate and free requests through the datapath.
`timescale 1ns / 1ps

module sba_ctrl
    import sba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic action,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy,
    output logic done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_RANGE,
        S_CHECK,
        S_DIV,
        S_FETCH,
        S_COMMIT,
        S_MUL,
        S_ADD,
        S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;
    logic   done_reg;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status_code = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (action == ACT_FREE) ? S_RANGE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_found)
                begin
                    state_next = S_MUL;
                end
                else if (sts.scan_last)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_FULL;
                    state_next      = S_RESP;
                end
            end
            S_RANGE:
            begin
                cmd.range_calc = 1'b1;
                state_next     = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.outside)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_OUTSIDE;
                    state_next      = S_RESP;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_FETCH;
                end
            end
            // Map word of the freed object is read in this cycle
            S_FETCH:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (sts.is_used)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_DOUBLE;
                    state_next      = S_RESP;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= (state_next == S_RESP);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    // Result strobe lasts one cycle and the block is then free
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> (!done_reg && !busy_reg))
        else $error("result strobe longer than one cycle");

    // Accepted request makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> busy_reg)
        else $error("request accepted without going busy");

    // Strobe only while a request is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> busy_reg)
        else $error("result strobe while idle");

endmodule

@@ hw/rtl/sba_datapath.sv @@
// Datapath: config registers, used-bit map, free count, scan, divider and address unit.
`timescale 1ns / 1ps

module sba_datapath
    import sba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  req_t                 request,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    output rsp_t                 result
);

    // Configuration
    logic [ADDR_W-1:0]      cfg_base_reg;
    logic [STRIDE_W-1:0]    cfg_stride_reg;
    logic [COUNT_W-1:0]     cfg_count_reg;

    // Slab state: used map as one SCAN_W-bit word per chunk; a word whose
    // flag is clear reads as all free
    logic [SCAN_W-1:0]      map_mem [CHUNKS];
    logic [CHUNKS-1:0]      word_valid_reg;
    logic [SCAN_W-1:0]      word_data_reg;
    logic                   word_ok_reg;
    logic [COUNT_W-1:0]     free_total_reg;

    // Per-request working registers
    logic [ADDR_W-1:0]      address_reg;
    logic [ADDR_W-1:0]      offset_reg;
    logic [SPAN_W-1:0]      span_reg;
    logic [CHUNK_W-1:0]     chunk_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [ADDR_W-1:0]      addr_reg;
    status_t                status_reg;

    logic [COUNT_W-1:0]     count_eff;
    logic [STRIDE_W-1:0]    stride_eff;
    logic [SCAN_W-1:0]      map_word;
    logic [CHUNK_W-1:0]     rd_addr;
    logic                   wr_en;
    logic [CHUNK_W-1:0]     wr_addr;
    logic [SCAN_W-1:0]      wr_data;
    logic [CHUNK_W-1:0]     idx_chunk;
    logic [SCAN_SEL_W-1:0]  idx_sel;
    logic [SCAN_W-1:0]      avail;
    logic                   scan_found;
    logic [SCAN_SEL_W-1:0]  scan_sel;
    logic [IDX_W-1:0]       scan_idx;
    logic [COUNT_W-1:0]     next_base;
    logic [REM_W-1:0]       rem;
    logic [REM_W-1:0]       trial;
    logic                   rem_ge;

    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] c);
        return (c > COUNT_W'(MAX_OBJECTS)) ? COUNT_W'(MAX_OBJECTS) : c;
    endfunction

    assign count_eff  = clamp_count(cfg_count_reg);
    assign stride_eff = (cfg_stride_reg == '0) ? STRIDE_W'(1) : cfg_stride_reg;

    assign idx_chunk = idx_reg[IDX_W-1:SCAN_SEL_W];
    assign idx_sel   = idx_reg[SCAN_SEL_W-1:0];
    assign map_word  = word_ok_reg ? word_data_reg : '0;

    // Map read address: chunk 0 on capture, the next chunk while scanning,
    // else the chunk of the object being freed
    always_comb
    begin
        if (cmd.capture)
        begin
            rd_addr = '0;
        end
        else if (cmd.scan)
        begin
            rd_addr = chunk_reg + CHUNK_W'(1);
        end
        else
        begin
            rd_addr = idx_chunk;
        end
    end

    // Map write: set the allocated bit or clear the freed one
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_chunk;
        wr_data = map_word & ~(SCAN_W'(1) << idx_sel);
        if (cmd.scan && scan_found)
        begin
            wr_en   = 1'b1;
            wr_addr = chunk_reg;
            wr_data = map_word | (SCAN_W'(1) << scan_sel);
        end
        else if (cmd.commit)
        begin
            wr_en = 1'b1;
        end
    end

    // Map memory with registered read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        word_data_reg <= map_mem[rd_addr];
        word_ok_reg   <= word_valid_reg[rd_addr];
    end

    // Lowest free object within the current chunk, bounded by the slab size
    always_comb
    begin
        logic [IDX_W-1:0] bidx;
        avail      = '0;
        scan_found = 1'b0;
        scan_sel   = '0;
        for (int j = 0; j < SCAN_W; j++)
        begin
            bidx     = {chunk_reg, SCAN_SEL_W'(j)};
            avail[j] = !map_word[j] && (COUNT_W'(bidx) < count_eff);
        end
        for (int j = SCAN_W - 1; j >= 0; j--)
        begin
            if (avail[j])
            begin
                scan_found = 1'b1;
                scan_sel   = SCAN_SEL_W'(j);
            end
        end
    end

    assign scan_idx  = {chunk_reg, scan_sel};
    assign next_base = COUNT_W'({chunk_reg, {SCAN_SEL_W{1'b0}}}) + COUNT_W'(SCAN_W);

    // Restoring divider step: one quotient bit per cycle, MSB first
    assign rem    = offset_reg[REM_W-1:0];
    assign trial  = REM_W'(stride_eff) << step_reg;
    assign rem_ge = (rem >= trial);

    assign sts.scan_found = scan_found;
    assign sts.scan_last  = (chunk_reg == CHUNK_W'(CHUNKS - 1)) || (next_base >= count_eff);
    assign sts.outside    = (offset_reg >= ADDR_W'(span_reg));
    assign sts.div_last   = (step_reg == '0);
    assign sts.is_used    = map_word[idx_sel];

    // Configuration and slab state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_base_reg   <= '0;
            cfg_stride_reg <= STRIDE_W'(32);
            cfg_count_reg  <= COUNT_W'(MAX_OBJECTS);
            word_valid_reg <= '0;
            free_total_reg <= COUNT_W'(MAX_OBJECTS);
        end
        else
        begin
            if (wr_en)
            begin
                word_valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.scan && scan_found)
            begin
                if (free_total_reg != '0)
                begin
                    free_total_reg <= free_total_reg - COUNT_W'(1);
                end
            end
            if (cmd.commit)
            begin
                if (free_total_reg < count_eff)
                begin
                    free_total_reg <= free_total_reg + COUNT_W'(1);
                end
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BASE:   cfg_base_reg   <= cfg_data;
                    REG_STRIDE: cfg_stride_reg <= cfg_data[STRIDE_W-1:0];
                    REG_COUNT:
                    begin
                        cfg_count_reg  <= cfg_data[COUNT_W-1:0];
                        word_valid_reg <= '0;
                        free_total_reg <= clamp_count(cfg_data[COUNT_W-1:0]);
                    end
                    default: ;
                endcase
            end
        end
    end

    // Request working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            address_reg <= request.address;
            chunk_reg   <= '0;
            idx_reg     <= '0;
            addr_reg    <= '0;
            status_reg  <= ST_OK;
        end
        if (cmd.scan)
        begin
            chunk_reg <= chunk_reg + CHUNK_W'(1);
            if (scan_found)
            begin
                idx_reg <= scan_idx;
            end
        end
        if (cmd.range_calc)
        begin
            offset_reg <= address_reg - cfg_base_reg;
            span_reg   <= SPAN_W'(count_eff) * SPAN_W'(stride_eff);
            step_reg   <= STEP_W'(IDX_W - 1);
        end
        if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                offset_reg <= ADDR_W'(rem - trial);
            end
            idx_reg  <= {idx_reg[IDX_W-2:0], rem_ge};
            step_reg <= step_reg - STEP_W'(1);
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(idx_reg) * PROD_W'(stride_eff);
        end
        if (cmd.add)
        begin
            addr_reg <= cfg_base_reg + ADDR_W'(prod_reg);
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
        end
    end

    assign result.status         = status_reg;
    assign result.object_address = addr_reg;
    assign result.object_index   = idx_reg;
    assign result.free_objects   = free_total_reg;

    // An allocated object lies inside the slab
    a_slot_in_slab: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && scan_found) |-> (COUNT_W'(scan_idx) < count_eff))
        else $error("allocated object outside the slab");

    // A free object found means the free count is not zero
    a_alloc_has_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && scan_found) |-> (free_total_reg != '0))
        else $error("free object found with zero free count");

    // Free count never exceeds the slab size
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        free_total_reg <= count_eff)
        else $error("free count above slab size");

    // A committed free clears a bit that was set
    a_commit_used: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (map_word[idx_sel] && !wr_data[idx_sel]))
        else $error("freed object was not marked used");

endmodule
